// File: sv/sct_pkg.sv
// Shared types, constants and helpers for the Taylor sine/cosine pipeline.
// Used by every module of the block; depends on nothing.
package sct_pkg;

    localparam int unsigned SERIES_TERMS_DEF = 6;
    localparam int unsigned ANGLE_WIDTH_DEF  = 32;
    localparam int unsigned MAX_TERMS        = 10;

    // Angle format keeps 8 integer bits (sign included) at any width.
    localparam int unsigned INT_BITS     = 8;
    localparam int unsigned PI_FRAC      = 61;
    localparam logic [63:0] PI_Q61       = 64'h6487ED5110B4611A;
    // Quotient of the fold never exceeds 31: |angle| <= 128 rad.
    localparam int unsigned REDUCE_STEPS = 5;

    // Working format: Q.58, carried as sign and 63-bit magnitude.
    localparam int unsigned WORK_FRAC  = 58;
    localparam int unsigned MAG_W      = 63;
    localparam int unsigned SUM_W      = MAG_W + 1;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned HI_W       = MAG_W - HALF_W;
    localparam int unsigned PROD_W     = 2 * MAG_W + 1;
    localparam int unsigned MUL_STAGES = 3;

    localparam logic [SUM_W-1:0] WORK_ONE = SUM_W'(1) << WORK_FRAC;
    localparam logic [MAG_W-1:0] MAG_MAX  = '1;

    // Result format Q2.30.
    localparam int unsigned OUT_W     = 32;
    localparam int unsigned OUT_FRAC  = 30;
    localparam int unsigned OUT_SHIFT = WORK_FRAC - OUT_FRAC;
    localparam int unsigned RND_W     = SUM_W - OUT_SHIFT;
    localparam logic [RND_W-1:0] POS_LIM = RND_W'(33'h07FFFFFFF);
    localparam logic [RND_W-1:0] NEG_LIM = RND_W'(33'h080000000);

    // 2^58 / (2i(2i+1)) and 2^58 / (2i(2i-1)), rounded half up.
    localparam logic [MAG_W-1:0] RECIP_SIN [1:MAX_TERMS] = '{
        MAG_W'((WORK_ONE + 64'd3)   / 64'd6),
        MAG_W'((WORK_ONE + 64'd10)  / 64'd20),
        MAG_W'((WORK_ONE + 64'd21)  / 64'd42),
        MAG_W'((WORK_ONE + 64'd36)  / 64'd72),
        MAG_W'((WORK_ONE + 64'd55)  / 64'd110),
        MAG_W'((WORK_ONE + 64'd78)  / 64'd156),
        MAG_W'((WORK_ONE + 64'd105) / 64'd210),
        MAG_W'((WORK_ONE + 64'd136) / 64'd272),
        MAG_W'((WORK_ONE + 64'd171) / 64'd342),
        MAG_W'((WORK_ONE + 64'd210) / 64'd420)
    };
    localparam logic [MAG_W-1:0] RECIP_COS [1:MAX_TERMS] = '{
        MAG_W'((WORK_ONE + 64'd1)   / 64'd2),
        MAG_W'((WORK_ONE + 64'd6)   / 64'd12),
        MAG_W'((WORK_ONE + 64'd15)  / 64'd30),
        MAG_W'((WORK_ONE + 64'd28)  / 64'd56),
        MAG_W'((WORK_ONE + 64'd45)  / 64'd90),
        MAG_W'((WORK_ONE + 64'd66)  / 64'd132),
        MAG_W'((WORK_ONE + 64'd91)  / 64'd182),
        MAG_W'((WORK_ONE + 64'd120) / 64'd240),
        MAG_W'((WORK_ONE + 64'd153) / 64'd306),
        MAG_W'((WORK_ONE + 64'd190) / 64'd380)
    };

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    // Word passed from cell to cell.
    typedef struct packed {
        sm_t              xsq;
        sm_t              term_s;
        sm_t              term_c;
        logic [SUM_W-1:0] sum_s;
        logic [SUM_W-1:0] sum_c;
    } cell_word_t;

    // Two's complement accumulate of a sign-magnitude value, one adder.
    function automatic logic [SUM_W-1:0] sm_accum(input logic [SUM_W-1:0] acc,
                                                  input sm_t v);
        logic [SUM_W-1:0] addend;
        addend = {1'b0, v.mag};
        if (v.neg) begin
            addend = ~addend;
        end
        return acc + addend + SUM_W'(v.neg);
    endfunction

endpackage

// File: sv/sct_ctl.sv
// Valid bits and load enables for a run of pipeline stages with bubble squeeze.
// Depends on sct_pkg.
module sct_ctl #(
    parameter int unsigned STAGES = sct_pkg::MUL_STAGES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAGES-1:0] en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // a stage loads when empty or when its contents move on
    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
        valid_next = (en & {valid_reg[STAGES-2:0], in_valid}) | (~en & valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

// File: sv/sct_mul.sv
// Three-stage Q.58 sign-magnitude multiplier: partial products, rounded sum, saturate.
// Depends on sct_pkg.
module sct_mul (
    input  logic                               aclk,
    input  logic [sct_pkg::MUL_STAGES-1:0]     en,
    input  sct_pkg::sm_t                       a,
    input  sct_pkg::sm_t                       b,
    output sct_pkg::sm_t                       p
);

    localparam int unsigned HALF_W = sct_pkg::HALF_W;
    localparam int unsigned HI_W   = sct_pkg::HI_W;
    localparam int unsigned MAG_W  = sct_pkg::MAG_W;
    localparam int unsigned PROD_W = sct_pkg::PROD_W;
    localparam int unsigned FRAC   = sct_pkg::WORK_FRAC;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (FRAC - 1);

    logic [2*HALF_W-1:0]    pp00_reg;
    logic [HALF_W+HI_W-1:0] pp01_reg;
    logic [HALF_W+HI_W-1:0] pp10_reg;
    logic [2*HI_W-1:0]      pp11_reg;
    logic                   neg1_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   neg2_reg;
    sct_pkg::sm_t           p_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pp00_reg <= a.mag[HALF_W-1:0] * b.mag[HALF_W-1:0];
            pp01_reg <= a.mag[HALF_W-1:0] * b.mag[MAG_W-1:HALF_W];
            pp10_reg <= a.mag[MAG_W-1:HALF_W] * b.mag[HALF_W-1:0];
            pp11_reg <= a.mag[MAG_W-1:HALF_W] * b.mag[MAG_W-1:HALF_W];
            neg1_reg <= a.neg ^ b.neg;
        end
        if (en[1]) begin
            // round-half-up on the magnitude = ties away from zero
            prod_reg <= PROD_W'(pp00_reg)
                      + (PROD_W'(pp01_reg) << HALF_W)
                      + (PROD_W'(pp10_reg) << HALF_W)
                      + (PROD_W'(pp11_reg) << (2 * HALF_W))
                      + ROUND;
            neg2_reg <= neg1_reg;
        end
        if (en[2]) begin
            p_reg.neg <= neg2_reg;
            if (|prod_reg[PROD_W-1:FRAC+MAG_W]) begin
                p_reg.mag <= sct_pkg::MAG_MAX;
            end else begin
                p_reg.mag <= prod_reg[FRAC+MAG_W-1:FRAC];
            end
        end
    end

    assign p = p_reg;

endmodule

// File: sv/sct_reduce.sv
// Angle folding into [-pi, pi] by restoring division against 2*pi, then x squared.
// Depends on sct_pkg, sct_ctl, sct_mul.
module sct_reduce #(
    parameter int unsigned ANGLE_WIDTH = sct_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ANGLE_WIDTH-1:0] in_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sct_pkg::cell_word_t    out_word
);

    localparam int unsigned W          = ANGLE_WIDTH;
    localparam int unsigned ANGLE_FRAC = W - sct_pkg::INT_BITS;
    localparam int unsigned PI_SHIFT   = sct_pkg::PI_FRAC - ANGLE_FRAC;
    localparam int unsigned WORK_SHIFT = sct_pkg::WORK_FRAC - ANGLE_FRAC;
    localparam int unsigned STEPS      = sct_pkg::REDUCE_STEPS;
    localparam int unsigned FOLD       = STEPS + 1;
    localparam int unsigned MS         = sct_pkg::MUL_STAGES;
    localparam int unsigned STAGES     = FOLD + 1 + MS;
    localparam int unsigned MAG_W      = sct_pkg::MAG_W;

    localparam logic [W-1:0] PI_A =
        W'((sct_pkg::PI_Q61 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT);
    localparam logic [W-1:0] PI_M1  = W'(PI_A - 1);
    localparam logic [W-1:0] TWO_PI = W'(PI_A << 1);
    localparam logic [W:0]   PM1_EXT = {1'b0, PI_M1};

    logic [STAGES-1:0] en;

    logic [W-1:0]  rem_reg [0:STEPS];
    logic          neg_reg [0:STEPS];
    logic [W-1:0]  rem_next [1:STEPS];
    logic [W:0]    ext;
    logic [W:0]    u_sum;
    logic          ge;
    logic [W-1:0]  r_mag;
    sct_pkg::sm_t  fold_next;
    sct_pkg::sm_t  fold_reg;
    sct_pkg::sm_t  xc_reg [0:MS-1];
    sct_pkg::sm_t  xsq;

    sct_ctl #(.STAGES(STAGES)) u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    // fold |x| by u = |x| + pi - 1; u mod 2*pi - (pi - 1) lands in (-pi, pi]
    always_comb begin
        ext   = {in_angle[W-1], in_angle};
        u_sum = in_angle[W-1] ? (PM1_EXT - ext) : (ext + PM1_EXT);
        for (int j = 1; j <= STEPS; j++) begin
            rem_next[j] = (rem_reg[j-1] >= W'(TWO_PI << (STEPS - j)))
                        ? rem_reg[j-1] - W'(TWO_PI << (STEPS - j))
                        : rem_reg[j-1];
        end
        ge    = rem_reg[STEPS] >= PI_M1;
        r_mag = ge ? (rem_reg[STEPS] - PI_M1) : (PI_M1 - rem_reg[STEPS]);
        fold_next.neg = neg_reg[STEPS] ^ !ge;
        fold_next.mag = MAG_W'(r_mag) << WORK_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= u_sum[W-1:0];
            neg_reg[0] <= in_angle[W-1];
        end
        for (int j = 1; j <= STEPS; j++) begin
            if (en[j]) begin
                rem_reg[j] <= rem_next[j];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
        if (en[FOLD]) begin
            fold_reg <= fold_next;
        end
        if (en[FOLD+1]) begin
            xc_reg[0] <= fold_reg;
        end
        for (int k = 1; k < MS; k++) begin
            if (en[FOLD+1+k]) begin
                xc_reg[k] <= xc_reg[k-1];
            end
        end
    end

    sct_mul u_square (
        .aclk (aclk),
        .en   (en[STAGES-1:FOLD+1]),
        .a    (fold_reg),
        .b    (fold_reg),
        .p    (xsq)
    );

    always_comb begin
        out_word.xsq        = xsq;
        out_word.term_s     = xc_reg[MS-1];
        out_word.term_c.neg = 1'b0;
        out_word.term_c.mag = MAG_W'(sct_pkg::WORK_ONE);
        out_word.sum_s      = '0;
        out_word.sum_c      = '0;
    end

endmodule

// File: sv/sct_cell.sv
// One series term for sine and cosine: coefficient -x^2/d, then term update and sum.
// Depends on sct_pkg, sct_ctl, sct_mul.
module sct_cell #(
    parameter int unsigned INDEX = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sct_pkg::cell_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output sct_pkg::cell_word_t out_word
);

    localparam int unsigned MS     = sct_pkg::MUL_STAGES;
    localparam int unsigned STAGES = 2 * MS;
    localparam int unsigned SUM_W  = sct_pkg::SUM_W;

    logic [STAGES-1:0] en;

    sct_pkg::sm_t     xsq_reg   [0:STAGES-1];
    logic [SUM_W-1:0] sum_s_reg [0:STAGES-1];
    logic [SUM_W-1:0] sum_c_reg [0:STAGES-1];
    sct_pkg::sm_t     ts_reg    [0:MS-1];
    sct_pkg::sm_t     tc_reg    [0:MS-1];

    sct_pkg::sm_t rs;
    sct_pkg::sm_t rc;
    sct_pkg::sm_t coef_s;
    sct_pkg::sm_t coef_c;
    sct_pkg::sm_t fs;
    sct_pkg::sm_t fc;
    sct_pkg::sm_t term_s;
    sct_pkg::sm_t term_c;

    sct_ctl #(.STAGES(STAGES)) u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    always_comb begin
        rs.neg = 1'b0;
        rs.mag = sct_pkg::RECIP_SIN[INDEX];
        rc.neg = 1'b0;
        rc.mag = sct_pkg::RECIP_COS[INDEX];
        // factor is minus x^2/d
        fs.neg = 1'b1;
        fs.mag = coef_s.mag;
        fc.neg = 1'b1;
        fc.mag = coef_c.mag;
    end

    // previous term joins the sum on entry; it also waits for its factor
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            xsq_reg[0]   <= in_word.xsq;
            sum_s_reg[0] <= sct_pkg::sm_accum(in_word.sum_s, in_word.term_s);
            sum_c_reg[0] <= sct_pkg::sm_accum(in_word.sum_c, in_word.term_c);
            ts_reg[0]    <= in_word.term_s;
            tc_reg[0]    <= in_word.term_c;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                xsq_reg[k]   <= xsq_reg[k-1];
                sum_s_reg[k] <= sum_s_reg[k-1];
                sum_c_reg[k] <= sum_c_reg[k-1];
            end
        end
        for (int k = 1; k < MS; k++) begin
            if (en[k]) begin
                ts_reg[k] <= ts_reg[k-1];
                tc_reg[k] <= tc_reg[k-1];
            end
        end
    end

    sct_mul u_coef_s (
        .aclk (aclk),
        .en   (en[MS-1:0]),
        .a    (in_word.xsq),
        .b    (rs),
        .p    (coef_s)
    );

    sct_mul u_coef_c (
        .aclk (aclk),
        .en   (en[MS-1:0]),
        .a    (in_word.xsq),
        .b    (rc),
        .p    (coef_c)
    );

    sct_mul u_term_s (
        .aclk (aclk),
        .en   (en[STAGES-1:MS]),
        .a    (ts_reg[MS-1]),
        .b    (fs),
        .p    (term_s)
    );

    sct_mul u_term_c (
        .aclk (aclk),
        .en   (en[STAGES-1:MS]),
        .a    (tc_reg[MS-1]),
        .b    (fc),
        .p    (term_c)
    );

    always_comb begin
        out_word.xsq    = xsq_reg[STAGES-1];
        out_word.term_s = term_s;
        out_word.term_c = term_c;
        out_word.sum_s  = sum_s_reg[STAGES-1];
        out_word.sum_c  = sum_c_reg[STAGES-1];
    end

endmodule

// File: sv/sine_cosine_taylor.sv
// Top level: pipelined Taylor-series sine and cosine of a fixed-point angle.
// Depends on sct_pkg, sct_ctl, sct_mul, sct_reduce, sct_cell.
//
// Channel  Ports      Dir  Word contents (lowest bit up)
// -------  ---------  ---  --------------------------------------------------
// angle    s_axis_*   in   angle, signed Q8.(ANGLE_WIDTH-8) rad, zero padded
// result   m_axis_*   out  sine Q2.30 [31:0], cosine Q2.30 [63:32], signed
//
// Throughput: one word per cycle, sustained while the output is not stalled.
// Path: the reducer, one cell per series term, then the output tail; each series term
//   chains two three-stage multipliers built from partial products of 32-bit halves.
// Reset: aresetn (synchronous, active low) clears every stage valid bit only.
// Stalls: a stage holds while its successor is full and stalled; empty stages
//   keep filling, so a new angle is taken while a finished word waits.
module sine_cosine_taylor #(
    parameter  int unsigned SERIES_TERMS = sct_pkg::SERIES_TERMS_DEF,
    parameter  int unsigned ANGLE_WIDTH  = sct_pkg::ANGLE_WIDTH_DEF,
    localparam int unsigned S_TDATA_W    = ((ANGLE_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // angle
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata    // sine, cosine
);

    localparam int unsigned SUM_W     = sct_pkg::SUM_W;
    localparam int unsigned RND_W     = sct_pkg::RND_W;
    localparam int unsigned OUT_W     = sct_pkg::OUT_W;
    localparam int unsigned OUT_SHIFT = sct_pkg::OUT_SHIFT;
    localparam int unsigned FIN_STAGES = 4;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (OUT_SHIFT - 1);

    // link 0 leaves the reducer; link i leaves term cell i
    sct_pkg::cell_word_t link_word  [0:SERIES_TERMS];
    logic [SERIES_TERMS:0] link_valid;
    logic [SERIES_TERMS:0] link_ready;

    logic [FIN_STAGES-1:0] fin_en;

    sct_reduce #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_angle  (s_axis_tdata[ANGLE_WIDTH-1:0]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_word  (link_word[0])
    );

    for (genvar i = 1; i <= SERIES_TERMS; i++) begin : g_term
        sct_cell #(.INDEX(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i-1]),
            .in_ready  (link_ready[i-1]),
            .in_word   (link_word[i-1]),
            .out_valid (link_valid[i]),
            .out_ready (link_ready[i]),
            .out_word  (link_word[i])
        );
    end

    sct_ctl #(.STAGES(FIN_STAGES)) u_fin_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[SERIES_TERMS]),
        .in_ready  (link_ready[SERIES_TERMS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (fin_en)
    );

    // Output tail, index 0 = sine, 1 = cosine:
    //   add the last term, take magnitude, round to Q2.30 and clip, restore sign.
    logic [SUM_W-1:0] sum_reg  [0:1];
    logic [SUM_W-1:0] mag_reg  [0:1];
    logic             neg1_reg [0:1];
    logic [OUT_W-1:0] clip_reg [0:1];
    logic             neg2_reg [0:1];
    logic [OUT_W-1:0] res_reg  [0:1];

    logic [SUM_W-1:0] sum_next  [0:1];
    logic [SUM_W-1:0] mag_next  [0:1];
    logic [SUM_W-1:0] rnd_full  [0:1];
    logic [RND_W-1:0] rnd       [0:1];
    logic [OUT_W-1:0] clip_next [0:1];

    always_comb begin
        sum_next[0] = sct_pkg::sm_accum(link_word[SERIES_TERMS].sum_s,
                                        link_word[SERIES_TERMS].term_s);
        sum_next[1] = sct_pkg::sm_accum(link_word[SERIES_TERMS].sum_c,
                                        link_word[SERIES_TERMS].term_c);
        for (int s = 0; s < 2; s++) begin
            mag_next[s] = sum_reg[s][SUM_W-1] ? (~sum_reg[s] + SUM_W'(1)) : sum_reg[s];
            rnd_full[s] = mag_reg[s] + HALF_LSB;
            rnd[s]      = rnd_full[s][SUM_W-1:OUT_SHIFT];
            // negative side reaches one step further than positive
            if (neg1_reg[s]) begin
                clip_next[s] = (rnd[s] > sct_pkg::NEG_LIM) ? OUT_W'(sct_pkg::NEG_LIM)
                                                           : rnd[s][OUT_W-1:0];
            end else begin
                clip_next[s] = (rnd[s] > sct_pkg::POS_LIM) ? OUT_W'(sct_pkg::POS_LIM)
                                                           : rnd[s][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < 2; s++) begin
            if (fin_en[0]) begin
                sum_reg[s] <= sum_next[s];
            end
            if (fin_en[1]) begin
                mag_reg[s]  <= mag_next[s];
                neg1_reg[s] <= sum_reg[s][SUM_W-1];
            end
            if (fin_en[2]) begin
                clip_reg[s] <= clip_next[s];
                neg2_reg[s] <= neg1_reg[s];
            end
            if (fin_en[3]) begin
                res_reg[s] <= neg2_reg[s] ? (~clip_reg[s] + OUT_W'(1)) : clip_reg[s];
            end
        end
    end

    assign m_axis_tdata = {res_reg[1], res_reg[0]};

endmodule

// File: bench/tb.sv
// Self-checking bench for sine_cosine_taylor: streams angles in and checks every
// sine/cosine word against a bit-exact Taylor-series predictor held here.
// Depends on sct_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TERMS   = 6;
    localparam int unsigned ANGLE_W = 32;
    // Pipeline depth: reducer stages, cell stages per term, output tail stages.
    localparam int unsigned LATENCY = 10 + 6 * TERMS + 4;

    localparam int unsigned WATCHDOG_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES      = 400;
    localparam int unsigned RANDOM_PER_PHASE = 265;

    // pi in Q8.24, rounded half up from its Q61 value; two pi is exactly twice it.
    localparam logic [63:0] PI_Q61       = 64'h6487ED5110B4611A;
    localparam longint      PI_ANGLE     = longint'((PI_Q61 + (64'd1 << 36)) >> 37);
    localparam longint      TWO_PI_ANGLE = 2 * PI_ANGLE;
    // 1.0 in the Q.58 working format.
    localparam longint      Q58_ONE      = longint'(64'd1 << 58);

    // Result word layout: sine in the low half, cosine in the high half.
    typedef struct packed {
        logic [31:0] cosine;
        logic [31:0] sine;
    } trig_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // angle
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // sine, cosine

    trig_word_t  expected_trig [$];      // predicted words, oldest first
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 0;     // chance per cycle that the sender idles
    int unsigned recv_stall_pct = 0;     // chance per cycle that the receiver stalls
    int unsigned hold_requests  = 0;     // bumped by a test to ask for a long hold-off
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned idle_cycles    = 0;

    sine_cosine_taylor #(
        .SERIES_TERMS (TERMS),
        .ANGLE_WIDTH  (ANGLE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Unsigned magnitude; the most negative value maps to 2^63.
    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Q.58 product, rounded to nearest with ties away from zero, saturated.
    function automatic longint q58_mul(input longint a, input longint b);
        logic [127:0] prod;
        logic [63:0]  mag;
        prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        prod = (prod + (128'd1 << 57)) >> 58;
        mag  = (prod > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : prod[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    // 1/d in Q.58, rounded half up.
    function automatic longint q58_recip(input longint d);
        return (Q58_ONE + d / 2) / d;
    endfunction

    // first is x for sine, 1.0 for cosine; each term is the last times -x^2/d.
    function automatic longint taylor_sum(input longint x, input longint first,
                                          input bit odd);
        longint xsq, term, acc, d, f;
        xsq  = q58_mul(x, x);
        term = first;
        acc  = first;
        for (int i = 1; i <= TERMS; i++) begin
            d    = longint'(2 * i) * longint'(odd ? 2 * i + 1 : 2 * i - 1);
            f    = -q58_mul(xsq, q58_recip(d));
            term = q58_mul(term, f);
            acc += term;
        end
        return acc;
    endfunction

    // Q.58 to Q2.30, ties away from zero, clipped to the 32-bit range.
    function automatic logic [31:0] round_q2_30(input longint v);
        logic [63:0] mag;
        mag = (mag64(v) + (64'd1 << 27)) >> 28;
        if (v < 0) begin
            return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Fold into [-pi, pi] by the fewest whole turns; exactly +/-pi is kept.
    function automatic longint fold_angle(input logic [31:0] raw);
        longint x, k;
        x = $signed(raw);
        if (x > PI_ANGLE) begin
            k = (x - PI_ANGLE + TWO_PI_ANGLE - 1) / TWO_PI_ANGLE;
            x -= k * TWO_PI_ANGLE;
        end else if (x < -PI_ANGLE) begin
            k = (-PI_ANGLE - x + TWO_PI_ANGLE - 1) / TWO_PI_ANGLE;
            x += k * TWO_PI_ANGLE;
        end
        return x;
    endfunction

    function automatic trig_word_t trig_of_angle(input logic [31:0] raw);
        longint     w;
        trig_word_t r;
        w        = fold_angle(raw) * (longint'(1) << 34);   // Q8.24 -> Q.58, exact
        r.sine   = round_q2_30(taylor_sum(w, w, 1'b1));
        r.cosine = round_q2_30(taylor_sum(w, Q58_ONE, 1'b0));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly raw patterns and in-range angles, plus angles that land just
    // either side of a fold boundary and single-bit patterns or their complements.
    function automatic logic [31:0] random_angle();
        longint a;
        longint b;
        case ($urandom_range(9)) inside
            [0:3]: begin
                a = $urandom;
            end
            [4:6]: begin
                a = longint'($urandom_range(32'(TWO_PI_ANGLE))) - PI_ANGLE;
            end
            [7:8]: begin
                // up to 19 whole turns, then a few LSBs around +/-pi
                a = (longint'($urandom_range(38)) - 19) * TWO_PI_ANGLE
                    + ($urandom_range(1) ? PI_ANGLE : -PI_ANGLE)
                    + longint'($urandom_range(8)) - 4;
            end
            default: begin
                b = longint'(1) << $urandom_range(31);
                a = $urandom_range(1) ? b : ~b;
            end
        endcase
        return a[31:0];
    endfunction

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Offer one angle word; the prediction is queued once the word is taken.
    task automatic send_angle(input logic [31:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        do @(posedge aclk); while (!s_axis_tready);
        expected_trig.push_back(trig_of_angle(angle));
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_trig.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, exact +/-pi (kept, not folded), one LSB either side of
    // the fold, whole turns, multi-turn folds that land on pi, and the
    // extreme codes that need the largest fold.
    task automatic test_directed();
        logic [31:0] corner [$];
        corner = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'h00FF_FFFF,
            32'(PI_ANGLE), 32'(-PI_ANGLE),
            32'(PI_ANGLE + 1), 32'(-PI_ANGLE - 1),
            32'(PI_ANGLE - 1), 32'(-PI_ANGLE + 1),
            32'(TWO_PI_ANGLE), 32'(-TWO_PI_ANGLE),
            32'(PI_ANGLE / 2), 32'(-PI_ANGLE / 2),
            32'(3 * PI_ANGLE), 32'(-3 * PI_ANGLE), 32'(3 * PI_ANGLE + 1),
            32'(19 * TWO_PI_ANGLE + PI_ANGLE), 32'(-19 * TWO_PI_ANGLE - PI_ANGLE),
            32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000
        };
        set_idling(0, 0);
        foreach (corner[i]) begin
            send_angle(corner[i]);
        end
        pause_until_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the pipe fills and input ready must drop.
    task automatic test_backpressure_fill();
        set_idling(0, 0);
        hold_requests <= hold_requests + 1;
        repeat (150) begin
            send_angle(random_angle());
        end
        pause_until_drained();
    endtask

    // Short bursts, each followed by a full drain of the pipe.
    task automatic test_drain_pause();
        set_idling(37, 37);
        repeat (3) begin
            repeat (20) begin
                send_angle(random_angle());
            end
            pause_until_drained();
        end
    endtask

    // Bulk random angles under each idling mix in turn.
    task automatic test_random_phases();
        int unsigned send_mix [4] = '{0, 81, 0, 37};
        int unsigned recv_mix [4] = '{0, 0, 81, 37};
        for (int p = 0; p < 4; p++) begin
            set_idling(send_mix[p], recv_mix[p]);
            repeat (RANDOM_PER_PHASE) begin
                send_angle(random_angle());
            end
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure_fill();
        test_drain_pause();
        test_random_phases();

        // let any stray extra word surface before judging
        repeat (LATENCY + 20) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check each taken word, then choose the next ready
    // ------------------------------------------------------------------

    task automatic check_trig(input trig_word_t got);
        trig_word_t want;
        if (expected_trig.size() == 0) begin
            $error("unexpected result word: sine %0d cosine %0d",
                   $signed(got.sine), $signed(got.cosine));
            error_count++;
            return;
        end
        want = expected_trig.pop_front();
        if (got.sine !== want.sine) begin
            $error("sine: expected %0d, got %0d", $signed(want.sine), $signed(got.sine));
            error_count++;
        end
        if (got.cosine !== want.cosine) begin
            $error("cosine: expected %0d, got %0d",
                   $signed(want.cosine), $signed(got.cosine));
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            check_trig(trig_word_t'(m_axis_tdata));
        end
        // a new hold-off request restarts the long stall count
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles in a row with no word taken on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
